/* rtl/core/acf_pkg.sv */
`timescale 1ns / 1ps

package acf_pkg;

	// Field widths
	localparam int CMD_W   = 1;
	localparam int IDX_W   = 3;
	localparam int NORM_W  = 18;
	localparam int COORD_W = 32;
	localparam int OFF_W   = 32;
	localparam int VIS_W   = 2;
	localparam int SEL_W   = 3;

	// Arithmetic widths: coord * normal is exact in PROD_W, three products
	// plus the offset scaled by 2^FRAC_W are exact in SUM_W
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = COORD_W + NORM_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int OFF_EXT = SUM_W - OFF_W - FRAC_W;

	localparam int NUM_PLANES_DEF = 6;

	// Commands
	localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
	localparam logic [CMD_W-1:0] CMD_TEST = 1'b1;

	// Visibility codes
	localparam logic [VIS_W-1:0] VIS_INSIDE  = 2'd0;
	localparam logic [VIS_W-1:0] VIS_PARTIAL = 2'd1;
	localparam logic [VIS_W-1:0] VIS_OUTSIDE = 2'd2;

	// Corner-select bit positions
	localparam int SEL_X = 2;
	localparam int SEL_Y = 1;
	localparam int SEL_Z = 0;

	// One word as it travels down the chain of plane cells
	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic [IDX_W-1:0]          plane_index;
		logic signed [NORM_W-1:0]  normal_x;
		logic signed [NORM_W-1:0]  normal_y;
		logic signed [NORM_W-1:0]  normal_z;
		logic signed [OFF_W-1:0]   plane_offset;
		logic signed [COORD_W-1:0] min_x;
		logic signed [COORD_W-1:0] min_y;
		logic signed [COORD_W-1:0] min_z;
		logic signed [COORD_W-1:0] max_x;
		logic signed [COORD_W-1:0] max_y;
		logic signed [COORD_W-1:0] max_z;
		logic                      outside;
		logic                      partial;
	} word_t;

	typedef struct packed {
		logic  valid;
		word_t word;
	} link_t;

endpackage

/* rtl/core/acf_if.sv */
`timescale 1ns / 1ps

// Request channel: plane loads and box tests
interface acf_req_if;
	import acf_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic [IDX_W-1:0]          plane_index;
	logic signed [NORM_W-1:0]  normal_x;
	logic signed [NORM_W-1:0]  normal_y;
	logic signed [NORM_W-1:0]  normal_z;
	logic signed [OFF_W-1:0]   plane_offset;
	logic signed [COORD_W-1:0] min_x;
	logic signed [COORD_W-1:0] min_y;
	logic signed [COORD_W-1:0] min_z;
	logic signed [COORD_W-1:0] max_x;
	logic signed [COORD_W-1:0] max_y;
	logic signed [COORD_W-1:0] max_z;

	modport source (
		output valid, command, plane_index, normal_x, normal_y, normal_z, plane_offset,
		output min_x, min_y, min_z, max_x, max_y, max_z,
		input  ready
	);

	modport sink (
		input  valid, command, plane_index, normal_x, normal_y, normal_z, plane_offset,
		input  min_x, min_y, min_z, max_x, max_y, max_z,
		output ready
	);
endinterface

// Response channel: one visibility word per box test
interface acf_rsp_if;
	import acf_pkg::*;

	logic             valid;
	logic             ready;
	logic [VIS_W-1:0] visibility;

	modport source (output valid, visibility, input ready);
	modport sink (input valid, visibility, output ready);
endinterface

/* rtl/core/acf_cell.sv */
`timescale 1ns / 1ps

// One plane of the frustum: holds the plane, tests the passing box against
// it over two stages and takes its load when a matching load word passes.
module acf_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  acf_pkg::link_t link_in,
	output acf_pkg::link_t link_out
);
	import acf_pkg::*;

	typedef struct packed {
		logic signed [PROD_W-1:0] near_x;
		logic signed [PROD_W-1:0] near_y;
		logic signed [PROD_W-1:0] near_z;
		logic signed [PROD_W-1:0] far_x;
		logic signed [PROD_W-1:0] far_y;
		logic signed [PROD_W-1:0] far_z;
		logic signed [OFF_W-1:0]  offset;
	} prod_t;

	// Stored plane
	logic signed [NORM_W-1:0] nx_q, ny_q, nz_q;
	logic signed [OFF_W-1:0]  off_q;
	logic [SEL_W-1:0]         sel_q;

	logic  valid_s1, valid_s2;
	word_t word_s1, word_s2;
	word_t word_nxt;
	prod_t prod_s1;
	prod_t prod_c;

	logic signed [COORD_W-1:0] near_x, near_y, near_z, far_x, far_y, far_z;
	logic signed [SUM_W-1:0]   sum_near, sum_far, off_scaled;
	logic                      near_pos, far_pos, load_hit;

	assign load_hit = en && link_in.valid && (link_in.word.command == CMD_LOAD)
		&& (link_in.word.plane_index == IDX_W'(CELL_INDEX));

	// Plane store, select bits from the normal signs (zero counts as not positive)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q  <= '0;
			ny_q  <= '0;
			nz_q  <= '0;
			off_q <= '0;
			sel_q <= '0;
		end else if (load_hit) begin
			nx_q  <= link_in.word.normal_x;
			ny_q  <= link_in.word.normal_y;
			nz_q  <= link_in.word.normal_z;
			off_q <= link_in.word.plane_offset;
			sel_q[SEL_X] <= (link_in.word.normal_x > 0);
			sel_q[SEL_Y] <= (link_in.word.normal_y > 0);
			sel_q[SEL_Z] <= (link_in.word.normal_z > 0);
		end
	end

	// Corner pick and products
	always_comb begin
		near_x = sel_q[SEL_X] ? link_in.word.min_x : link_in.word.max_x;
		near_y = sel_q[SEL_Y] ? link_in.word.min_y : link_in.word.max_y;
		near_z = sel_q[SEL_Z] ? link_in.word.min_z : link_in.word.max_z;
		far_x  = sel_q[SEL_X] ? link_in.word.max_x : link_in.word.min_x;
		far_y  = sel_q[SEL_Y] ? link_in.word.max_y : link_in.word.min_y;
		far_z  = sel_q[SEL_Z] ? link_in.word.max_z : link_in.word.min_z;
		prod_c.near_x = near_x * nx_q;
		prod_c.near_y = near_y * ny_q;
		prod_c.near_z = near_z * nz_q;
		prod_c.far_x  = far_x * nx_q;
		prod_c.far_y  = far_y * ny_q;
		prod_c.far_z  = far_z * nz_q;
		prod_c.offset = off_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= link_in.valid;
			valid_s2 <= valid_s1;
		end
	end

	// Sums and sign test
	always_comb begin
		off_scaled = {{OFF_EXT{prod_s1.offset[OFF_W-1]}}, prod_s1.offset, FRAC_W'(0)};
		sum_near = SUM_W'(prod_s1.near_x) + SUM_W'(prod_s1.near_y)
			+ SUM_W'(prod_s1.near_z) + off_scaled;
		sum_far  = SUM_W'(prod_s1.far_x) + SUM_W'(prod_s1.far_y)
			+ SUM_W'(prod_s1.far_z) + off_scaled;
		near_pos = !sum_near[SUM_W-1] && (sum_near != '0);
		far_pos  = !sum_far[SUM_W-1] && (sum_far != '0);
		word_nxt         = word_s1;
		word_nxt.outside = word_s1.outside | near_pos;
		word_nxt.partial = word_s1.partial | far_pos;
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= link_in.word;
			prod_s1 <= prod_c;
			word_s2 <= word_nxt;
		end
	end

	assign link_out.valid = valid_s2;
	assign link_out.word  = word_s2;
endmodule

/* rtl/core/aabb_frustum_cull_top.sv */
`timescale 1ns / 1ps

// View-frustum culling of axis-aligned boxes against NUM_PLANES planes. Every
// request word (plane load or box test) flows down a chain of plane cells,
// two pipeline stages per cell. A test's visibility comes from the last
// cell's second stage, and one word is taken every cycle while the response
// side keeps up. A load updates its plane as it passes that cell, so later
// tests see it and earlier ones do not; loads give no response and an index
// beyond the planes is dropped. The last cell's stage is the output register;
// while it holds an untaken response the whole chain stalls.
module aabb_frustum_cull_top #(
	parameter int NUM_PLANES = acf_pkg::NUM_PLANES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	acf_req_if.sink    req,
	acf_rsp_if.source  rsp
);
	import acf_pkg::*;

	link_t chain [NUM_PLANES+1];
	logic  en;

	// Global advance: chain moves unless a response is held
	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;

	always_comb begin
		chain[0].valid             = req.valid;
		chain[0].word.command      = req.command;
		chain[0].word.plane_index  = req.plane_index;
		chain[0].word.normal_x     = req.normal_x;
		chain[0].word.normal_y     = req.normal_y;
		chain[0].word.normal_z     = req.normal_z;
		chain[0].word.plane_offset = req.plane_offset;
		chain[0].word.min_x        = req.min_x;
		chain[0].word.min_y        = req.min_y;
		chain[0].word.min_z        = req.min_z;
		chain[0].word.max_x        = req.max_x;
		chain[0].word.max_y        = req.max_y;
		chain[0].word.max_z        = req.max_z;
		chain[0].word.outside      = 1'b0;
		chain[0].word.partial      = 1'b0;
	end

	for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
		acf_cell #(.CELL_INDEX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.link_in  (chain[i]),
			.link_out (chain[i+1])
		);
	end

	// Only tests leave the chain as responses
	assign rsp.valid = chain[NUM_PLANES].valid
		&& (chain[NUM_PLANES].word.command == CMD_TEST);

	always_comb begin
		priority if (chain[NUM_PLANES].word.outside) begin
			rsp.visibility = VIS_OUTSIDE;
		end else if (chain[NUM_PLANES].word.partial) begin
			rsp.visibility = VIS_PARTIAL;
		end else begin
			rsp.visibility = VIS_INSIDE;
		end
	end
endmodule

/* rtl/core/acf_checker.sv */
`timescale 1ns / 1ps

module acf_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_ready,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input logic [acf_pkg::VIS_W-1:0] rsp_visibility
);
	import acf_pkg::*;

	// A held response stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// Only defined visibility codes come out
	a_vis_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_visibility == VIS_INSIDE) || (rsp_visibility == VIS_PARTIAL)
			|| (rsp_visibility == VIS_OUTSIDE))
		else $error("undefined visibility code");

	// A stalled response stops intake
	a_stall_intake: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while response stalled");

	// Free response side means the chain takes words
	a_free_intake: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("intake blocked with no response pending");
endmodule

bind aabb_frustum_cull_top acf_checker u_acf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_visibility (rsp.visibility)
);
